// ===== rtl/assert_macros.svh =====
// assertion macros shared by the position reply parser rtl
// expects i_clk and i_rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds at every clock edge out of reset
`define PRP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// consequence that must hold in the cycle after the trigger
`define PRP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/prp_pkg.sv =====
// shared types and constants of the position reply parser
// no dependencies
`default_nettype none

package prp_pkg;

    typedef logic [1:0] t_opcode;

    localparam t_opcode OP_BYTE    = 2'd0;
    localparam t_opcode OP_TICK    = 2'd1;
    localparam t_opcode OP_REQUEST = 2'd2;
    localparam t_opcode OP_DELTA   = 2'd3;

    localparam int KEY_LEN = 4;
    localparam logic [KEY_LEN-1:0][7:0] KEY_TEXT = {8'h3D, 8'h53, 8'h4F, 8'h50};

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [2:0] KEY_FOUND = 3'd4;

    localparam logic [1:0] PH_BLANKS = 2'd0;
    localparam logic [1:0] PH_DIGITS = 2'd1;
    localparam logic [1:0] PH_STOP   = 2'd2;

    localparam logic [31:0] MAG_CAP  = 32'h8000_0000;
    localparam logic [31:0] POS_MAX  = 32'h7FFF_FFFF;
    localparam logic [16:0] TICK_MAX = 17'h1_FFFF;

    localparam logic [15:0] TIMEOUT_RESET = 16'd50;
    localparam int          APB_ADDR_W    = 3;
    localparam logic [APB_ADDR_W-1:2] REG_TIMEOUT = 1'b0;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        t_opcode              op;
        logic                 is_nl;
        logic                 is_nul;
        logic                 is_blank;
        logic                 is_digit;
        logic                 is_minus;
        logic                 is_plus;
        logic [KEY_LEN-1:0]   key_hit;
        logic [3:0]           digit;
    } t_prp_cmd;

endpackage

`default_nettype wire

// ===== rtl/prp_in_if.sv =====
// input channel of the position reply parser: opcode and received byte
// no dependencies
`default_nettype none

interface prp_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] rx_byte;

    modport source (output valid, opcode, rx_byte, input ready);
    modport sink   (input valid, opcode, rx_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/prp_out_if.sv =====
// result channel of the position reply parser
// no dependencies
`default_nettype none

interface prp_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] position;
    logic signed [31:0] delta;
    logic               busy_res;
    logic               request_sent;
    logic               timed_out;
    logic               position_updated;

    modport source (output valid, position, delta, busy_res, request_sent, timed_out,
                    position_updated, input ready);
    modport sink   (input valid, position, delta, busy_res, request_sent, timed_out,
                    position_updated, output ready);
endinterface

`default_nettype wire

// ===== rtl/prp_front.sv =====
// front end: accepts input transfers and classifies the received byte
// depends on prp_pkg and prp_in_if
`default_nettype none

module prp_front
    import prp_pkg::*;
(
    prp_in_if.sink   i_cmd,
    input  logic     i_full,
    output logic     o_push,
    output t_prp_cmd o_cmd
);

    logic [7:0] b;

    assign b              = i_cmd.rx_byte;
    assign i_cmd.ready    = !i_full;
    assign o_push         = i_cmd.valid && !i_full;

    always_comb begin
        o_cmd          = '0;
        o_cmd.op       = i_cmd.opcode;
        o_cmd.is_nl    = (b == CH_NL);
        o_cmd.is_nul   = (b == CH_NUL);
        o_cmd.is_blank = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
        o_cmd.is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
        o_cmd.is_minus = (b == CH_MINUS);
        o_cmd.is_plus  = (b == CH_PLUS);
        o_cmd.digit    = b[3:0];
        for (int k = 0; k < KEY_LEN; k++) begin
            o_cmd.key_hit[k] = (b == KEY_TEXT[k]);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/prp_fifo.sv =====
// short queue of classified commands between front and back end
// depends on prp_pkg
`default_nettype none

module prp_fifo
    import prp_pkg::*;
`include "assert_macros.svh"
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_prp_cmd i_data,
    input  logic     i_pop,
    output logic     o_full,
    output logic     o_valid,
    output t_prp_cmd o_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_prp_cmd         r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    `PRP_ASSERT_ALWAYS(a_fifo_count, r_count <= CNT_W'(QUEUE_DEPTH), "queue count overflow")
    `PRP_ASSERT_NEXT(a_fifo_fill, do_push && !do_pop, r_count != '0, "push lost in queue")

endmodule

`default_nettype wire

// ===== rtl/prp_back.sv =====
// back end: line parser, request timer, delta tracking and result register
// depends on prp_pkg and prp_out_if
`default_nettype none

module prp_back
    import prp_pkg::*;
`include "assert_macros.svh"
#(
    parameter int LINE_LIMIT = 100
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    input  t_prp_cmd     i_cmd,
    input  logic [15:0]  i_timeout,
    output logic         o_pop,
    prp_out_if.source    o_res
);

    localparam int LEN_W = $clog2(LINE_LIMIT);

    logic [2:0]       r_key_stage, n_key_stage;
    logic [1:0]       r_phase, n_phase;
    logic             r_neg, n_neg;
    logic [31:0]      r_acc, n_acc;
    logic             r_ended, n_ended;
    logic [LEN_W-1:0] r_len, n_len;
    logic [31:0]      r_cur, n_cur;
    logic [31:0]      r_prev, n_prev;
    logic             r_busy, n_busy;
    logic [16:0]      r_ticks, n_ticks;

    logic             r_res_valid;
    logic [31:0]      r_delta, n_delta;
    logic             r_sent, n_sent;
    logic             r_expired, n_expired;
    logic             r_updated, n_updated;

    logic [35:0]      acc_mul;
    logic [31:0]      acc_sat;
    logic [31:0]      parsed;
    logic [16:0]      ticks_inc;
    logic             in_number;

    assign o_pop = i_valid && (!r_res_valid || o_res.ready);

    assign acc_mul   = 36'({r_acc, 3'b000}) + 36'({r_acc, 1'b0}) + 36'(i_cmd.digit);
    assign acc_sat   = (acc_mul > 36'(MAG_CAP)) ? MAG_CAP : acc_mul[31:0];
    assign parsed    = r_neg ? (32'd0 - r_acc) : ((r_acc > POS_MAX) ? POS_MAX : r_acc);
    assign ticks_inc = (r_ticks < TICK_MAX) ? r_ticks + 17'd1 : r_ticks;
    assign in_number = (r_phase == PH_DIGITS) ||
                       ((r_phase == PH_BLANKS) && !i_cmd.is_blank &&
                        !i_cmd.is_minus && !i_cmd.is_plus);

    always_comb begin
        n_key_stage = r_key_stage;
        n_phase     = r_phase;
        n_neg       = r_neg;
        n_acc       = r_acc;
        n_ended     = r_ended;
        n_len       = r_len;
        n_cur       = r_cur;
        n_prev      = r_prev;
        n_busy      = r_busy;
        n_ticks     = r_ticks;
        n_delta     = '0;
        n_sent      = 1'b0;
        n_expired   = 1'b0;
        n_updated   = 1'b0;
        unique case (i_cmd.op)
            OP_BYTE: begin
                if (i_cmd.is_nl || (r_len >= LEN_W'(LINE_LIMIT - 1))) begin
                    if (i_cmd.is_nl && (r_key_stage == KEY_FOUND)) begin
                        n_cur     = parsed;
                        n_busy    = 1'b0;
                        n_updated = 1'b1;
                    end
                    n_key_stage = '0;
                    n_phase     = PH_BLANKS;
                    n_neg       = 1'b0;
                    n_acc       = '0;
                    n_ended     = 1'b0;
                    n_len       = '0;
                end else begin
                    n_len = r_len + 1'b1;
                    if (!r_ended) begin
                        if (i_cmd.is_nul) begin
                            n_ended = 1'b1;
                        end else if (r_key_stage != KEY_FOUND) begin
                            if (i_cmd.key_hit[r_key_stage[1:0]]) begin
                                n_key_stage = r_key_stage + 3'd1;
                            end else begin
                                n_key_stage = {2'b00, i_cmd.key_hit[0]};
                            end
                        end else begin
                            if (r_phase == PH_BLANKS && !i_cmd.is_blank) begin
                                n_phase = PH_DIGITS;
                                n_neg   = i_cmd.is_minus;
                            end
                            if (in_number) begin
                                if (i_cmd.is_digit) begin
                                    n_acc = acc_sat;
                                end else begin
                                    n_phase = PH_STOP;
                                end
                            end
                        end
                    end
                end
            end
            OP_TICK: begin
                if (r_busy) begin
                    n_ticks = ticks_inc;
                    if (ticks_inc > {1'b0, i_timeout}) begin
                        n_busy    = 1'b0;
                        n_expired = 1'b1;
                    end
                end
            end
            OP_REQUEST: begin
                if (!r_busy) begin
                    n_busy  = 1'b1;
                    n_ticks = '0;
                    n_sent  = 1'b1;
                end
            end
            OP_DELTA: begin
                n_delta = r_cur - r_prev;
                n_prev  = r_cur;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_stage <= '0;
            r_phase     <= PH_BLANKS;
            r_neg       <= 1'b0;
            r_acc       <= '0;
            r_ended     <= 1'b0;
            r_len       <= '0;
            r_cur       <= '0;
            r_prev      <= '0;
            r_busy      <= 1'b0;
            r_ticks     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_key_stage <= n_key_stage;
                r_phase     <= n_phase;
                r_neg       <= n_neg;
                r_acc       <= n_acc;
                r_ended     <= n_ended;
                r_len       <= n_len;
                r_cur       <= n_cur;
                r_prev      <= n_prev;
                r_busy      <= n_busy;
                r_ticks     <= n_ticks;
                r_res_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_delta   <= n_delta;
            r_sent    <= n_sent;
            r_expired <= n_expired;
            r_updated <= n_updated;
        end
    end

    assign o_res.valid            = r_res_valid;
    assign o_res.position         = r_cur;
    assign o_res.delta            = r_delta;
    assign o_res.busy_res         = r_busy;
    assign o_res.request_sent     = r_sent;
    assign o_res.timed_out        = r_expired;
    assign o_res.position_updated = r_updated;

    `PRP_ASSERT_ALWAYS(a_key_stage, r_key_stage <= KEY_FOUND, "key stage out of range")
    `PRP_ASSERT_ALWAYS(a_acc_cap, r_acc <= MAG_CAP, "magnitude above cap")
    `PRP_ASSERT_NEXT(a_req_busy, o_pop && i_cmd.op == OP_REQUEST, r_busy, "request left idle")

endmodule

`default_nettype wire

// ===== rtl/position_reply_parser_unit.sv =====
// top level of the position reply parser: apb register, front end, queue, back end
// depends on prp_pkg, prp_in_if, prp_out_if, prp_front, prp_fifo and prp_back
`default_nettype none

// One command per cycle is accepted on i_cmd while the queue is not full: a received
// byte, a tick, a position request or a delta read. Each command gives exactly one
// result on o_res; the front end classifies the byte into a two-entry queue and the
// back end updates the line parser, request timer and delta state into a result
// register, so a stalled o_res stops intake only once the queue is full. timeout_limit
// (reset 50) is at apb addresses 0 to 3 (paddr bit 2 low); a write takes setup and
// access cycles, pready is always high, addresses with paddr bit 2 set read as zero.
// No clearing pass after reset.
module position_reply_parser_unit
    import prp_pkg::*;
#(
    parameter int LINE_LIMIT = 100
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    prp_in_if.sink                i_cmd,
    prp_out_if.source             o_res,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic [15:0] r_timeout;
    logic        reg_hit;
    logic        push;
    logic        pop;
    logic        full;
    logic        q_valid;
    t_prp_cmd    front_cmd;
    t_prp_cmd    q_cmd;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[APB_ADDR_W-1:2] == REG_TIMEOUT);
    assign prdata  = reg_hit ? {16'd0, r_timeout} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
        end else if (psel && penable && pwrite && reg_hit) begin
            r_timeout <= pwdata[15:0];
        end
    end

    prp_front u_front (
        .i_cmd  (i_cmd),
        .i_full (full),
        .o_push (push),
        .o_cmd  (front_cmd)
    );

    prp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (q_valid),
        .o_data  (q_cmd)
    );

    prp_back #(
        .LINE_LIMIT (LINE_LIMIT)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (q_valid),
        .i_cmd     (q_cmd),
        .i_timeout (r_timeout),
        .o_pop     (pop),
        .o_res     (o_res)
    );

endmodule

`default_nettype wire
